### src/email_syntax_checker_defines.svh
// Assertion macros used by the checker file.
`ifndef EMAIL_SYNTAX_CHECKER_DEFINES_SVH
`define EMAIL_SYNTAX_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define ESC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

  localparam logic [7:0]  CH_AT      = 8'h40;
  localparam logic [7:0]  CH_DOT     = 8'h2E;
  localparam logic [7:0]  CH_DASH    = 8'h2D;
  localparam logic [7:0]  CH_USCORE  = 8'h5F;
  localparam logic [7:0]  CH_NONE    = 8'h00;
  localparam logic [31:0] SUFFIX_COM = 32'h2E636F6D;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_EDGE   = 3'd1,
    ERR_PAIR   = 3'd2,
    ERR_AT2    = 3'd3,
    ERR_CHAR   = 3'd4,
    ERR_SUFFIX = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0]  first_char;
    logic [31:0] tail_window;
    logic        at_seen;
    err_t        early_error;
    logic        suffix_reached;
    logic        mid_address;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    first_char:     8'h00,
    tail_window:    32'h0,
    at_seen:        1'b0,
    early_error:    ERR_NONE,
    suffix_reached: 1'b0,
    mid_address:    1'b0
  };

  function automatic logic char_allowed(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
           c == CH_DOT || c == CH_DASH || c == CH_USCORE;
  endfunction

  function automatic logic edge_bad(input logic [7:0] c);
    return c == CH_AT || c == CH_DOT;
  endfunction

  // Judge one position from its character and the one after it.
  function automatic scan_state_t judge(input scan_state_t st, input logic [7:0] c,
                                        input logic [7:0] nxt);
    scan_state_t r;
    r = st;
    if (st.early_error == ERR_NONE) begin
      if ((c == CH_DOT || c == CH_AT) && nxt == CH_DOT) begin
        r.early_error = ERR_PAIR;
      end else if (c == CH_AT) begin
        if (st.at_seen) begin
          r.early_error = ERR_AT2;
        end else begin
          r.at_seen = 1'b1;
        end
      end else if (!char_allowed(c)) begin
        r.early_error = ERR_CHAR;
      end else begin
        r.suffix_reached = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

### src/esc_if.sv
`timescale 1ns / 1ps

interface esc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface esc_verdict_if;
  logic       valid;
  logic       ready;
  logic       address_ok;
  logic [2:0] error_code;

  modport source (output valid, output address_ok, output error_code, input ready);
  modport sink   (input valid, input address_ok, input error_code, output ready);
endinterface

### src/email_syntax_checker.sv
// The verdict is registered and becomes valid in the cycle after the transfer of the final character.
// Throughput: one character per cycle while no verdict waits; the scan state is updated at each accepted character.
// A verdict that waits to be taken holds off further characters until it is taken.
// Reset (rst, synchronous, active high) clears the scan state and drops the verdict.
`timescale 1ns / 1ps

module email_syntax_checker (
  input  logic                 clk,
  input  logic                 rst,
  esc_char_if.sink             char_in,
  esc_verdict_if.source        verdict_out
);

  esc_pkg::scan_state_t st;
  esc_pkg::scan_state_t st_next;
  esc_pkg::err_t        verdict;
  esc_pkg::err_t        res_err;
  logic                 res_valid;
  logic                 accept;

  esc_judge u_judge (
    .st        (st),
    .char_code (char_in.char_code),
    .st_next   (st_next),
    .verdict   (verdict)
  );

  assign char_in.ready = !res_valid || verdict_out.ready;
  assign accept        = char_in.valid && char_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= esc_pkg::SCAN_RESET;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        st <= char_in.last_char ? esc_pkg::SCAN_RESET : st_next;
      end
      if (accept && char_in.last_char) begin
        res_valid <= 1'b1;
      end else if (verdict_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && char_in.last_char) begin
      res_err <= verdict;
    end
  end

  assign verdict_out.valid      = res_valid;
  assign verdict_out.error_code = res_err;
  assign verdict_out.address_ok = (res_err == esc_pkg::ERR_NONE);

endmodule

### src/esc_judge.sv
`timescale 1ns / 1ps

module esc_judge (
  input  esc_pkg::scan_state_t st,
  input  logic [7:0]           char_code,
  output esc_pkg::scan_state_t st_next,
  output esc_pkg::err_t        verdict
);

  esc_pkg::scan_state_t s1;
  esc_pkg::scan_state_t s2;

  always_comb begin
    if (st.mid_address) begin
      s1 = esc_pkg::judge(st, st.tail_window[7:0], char_code);
    end else begin
      s1 = st;
      s1.first_char = char_code;
    end
    s1.tail_window = {st.tail_window[23:0], char_code};
    s1.mid_address = 1'b1;
    st_next = s1;

    // final position: nothing follows
    s2 = esc_pkg::judge(s1, char_code, esc_pkg::CH_NONE);
    if (esc_pkg::edge_bad(s1.first_char) || esc_pkg::edge_bad(char_code)) begin
      verdict = esc_pkg::ERR_EDGE;
    end else if (s2.suffix_reached && s2.tail_window != esc_pkg::SUFFIX_COM) begin
      verdict = esc_pkg::ERR_SUFFIX;
    end else begin
      verdict = s2.early_error;
    end
  end

endmodule

### src/esc_checker.sv
`timescale 1ns / 1ps
`include "email_syntax_checker_defines.svh"

module esc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_ok,
  input logic [2:0] out_code
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  `ESC_ASSERT_IMP(a_ok_matches_code, clk, rst, out_valid, out_ok == (out_code == esc_pkg::ERR_NONE), "address_ok disagrees with error_code")
  `ESC_ASSERT_IMP(a_code_range, clk, rst, out_valid, out_code <= esc_pkg::ERR_SUFFIX, "error_code out of range")
  `ESC_ASSERT_NXT(a_last_gives_verdict, clk, rst, in_xfer && in_last, out_valid, "no verdict after final character")
  `ESC_ASSERT_NXT(a_no_spurious, clk, rst, in_xfer && !in_last && (!out_valid || out_ready), !out_valid, "verdict without final character")
  `ESC_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_code), "stalled verdict dropped or changed")

endmodule

bind email_syntax_checker esc_checker u_esc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (char_in.valid),
  .in_ready  (char_in.ready),
  .in_last   (char_in.last_char),
  .out_valid (verdict_out.valid),
  .out_ready (verdict_out.ready),
  .out_ok    (verdict_out.address_ok),
  .out_code  (verdict_out.error_code)
);

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CHARS = 700;

  class verdict_scoreboard;
    typedef struct packed {
      logic          ok;
      esc_pkg::err_t code;
    } verdict_t;

    logic [7:0]    lead_char;
    logic [31:0]   recent_chars;
    logic          at_found;
    esc_pkg::err_t first_fault;
    logic          reached_suffix;
    logic          in_address;
    verdict_t      pending_verdicts[$];
    int            failures;

    function new();
      failures = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      lead_char      = esc_pkg::CH_NONE;
      recent_chars   = '0;
      at_found       = 1'b0;
      first_fault    = esc_pkg::ERR_NONE;
      reached_suffix = 1'b0;
      in_address     = 1'b0;
    endfunction

    // Judge a position once the character after it is known.
    function void assess(logic [7:0] c, logic [7:0] follower);
      if (first_fault != esc_pkg::ERR_NONE) return;
      if ((c == esc_pkg::CH_DOT || c == esc_pkg::CH_AT) && follower == esc_pkg::CH_DOT) begin
        first_fault = esc_pkg::ERR_PAIR;
      end else if (c == esc_pkg::CH_AT) begin
        if (at_found) first_fault = esc_pkg::ERR_AT2;
        else at_found = 1'b1;
      end else if (!((c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
                     c == esc_pkg::CH_DOT || c == esc_pkg::CH_DASH ||
                     c == esc_pkg::CH_USCORE)) begin
        first_fault = esc_pkg::ERR_CHAR;
      end else begin
        reached_suffix = 1'b1;
      end
    endfunction

    function void note_char(logic [7:0] c, logic fin);
      esc_pkg::err_t code;
      verdict_t      v;
      if (in_address) assess(recent_chars[7:0], c);
      else lead_char = c;
      recent_chars = {recent_chars[23:0], c};
      in_address   = 1'b1;
      if (fin) begin
        assess(c, esc_pkg::CH_NONE);
        if (lead_char == esc_pkg::CH_AT || lead_char == esc_pkg::CH_DOT ||
            c == esc_pkg::CH_AT || c == esc_pkg::CH_DOT)
          code = esc_pkg::ERR_EDGE;
        else if (reached_suffix && recent_chars != esc_pkg::SUFFIX_COM)
          code = esc_pkg::ERR_SUFFIX;
        else
          code = first_fault;
        v.ok   = (code == esc_pkg::ERR_NONE);
        v.code = code;
        pending_verdicts.push_back(v);
        clear_scan();
      end
    endfunction

    function void check_verdict(logic ok, logic [2:0] code);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("verdict with none expected: address_ok %0b error_code %0d", ok, code);
        failures++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (ok !== v.ok) begin
        $error("address_ok: expected %0b, got %0b", v.ok, ok);
        failures++;
      end
      if (code !== v.code) begin
        $error("error_code: expected %0d, got %0d", v.code, code);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady = 1'b0;
  int   stall_left = 0;
  int   cycles = 0;
  int   chars_sent = 0;

  verdict_scoreboard sb = new();

  esc_char_if    cin ();
  esc_verdict_if vout ();

  email_syntax_checker dut (
    .clk         (clk),
    .rst         (rst),
    .char_in     (cin),
    .verdict_out (vout)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("email_syntax_checker: mismatch");
      $finish;
    end
  end

  // Verdict sink: random stall bursts, no new ones once steady.
  always @(posedge clk) begin
    if (rst) begin
      vout.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      vout.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 10);
      vout.ready <= 1'b0;
    end else begin
      vout.ready <= 1'b1;
    end
    if (!rst && vout.valid === 1'b1 && vout.ready === 1'b1)
      sb.check_verdict(vout.address_ok, vout.error_code);
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    if (!steady && $urandom_range(0, 5) == 0) begin
      cin.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cin.valid     <= 1'b1;
    cin.char_code <= c;
    cin.last_char <= fin;
    do @(posedge clk); while (cin.ready !== 1'b1);
    sb.note_char(c, fin);
    chars_sent++;
  endtask

  task automatic send_address(input logic [7:0] addr[$]);
    foreach (addr[i]) send_char(addr[i], i == addr.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] addr[$];
    for (int i = 0; i < s.len(); i++) addr.push_back(s[i]);
    send_address(addr);
  endtask

  function automatic logic [7:0] legal_char();
    case ($urandom_range(0, 5))
      0, 1, 2, 3: return 8'($urandom_range("a", "z"));
      4:          return 8'($urandom_range("0", "9"));
      default:    return $urandom_range(0, 1) ? esc_pkg::CH_DASH : esc_pkg::CH_USCORE;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0:       return esc_pkg::CH_AT;
      1:       return esc_pkg::CH_DOT;
      2:       return legal_char();
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Mostly .com addresses, often damaged, some pure noise.
  task automatic send_random_address();
    logic [7:0] addr[$];
    int         pos;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) addr.push_back(noise_char());
    end else begin
      repeat ($urandom_range(1, 4))
        addr.push_back($urandom_range(0, 7) == 0 ? esc_pkg::CH_DOT : legal_char());
      addr.push_back(esc_pkg::CH_AT);
      repeat ($urandom_range(1, 3))
        addr.push_back($urandom_range(0, 7) == 0 ? esc_pkg::CH_DOT : legal_char());
      for (int k = 3; k >= 0; k--) addr.push_back(esc_pkg::SUFFIX_COM[8*k +: 8]);
      if ($urandom_range(0, 9) < 6) begin
        pos = $urandom_range(0, addr.size() - 1);
        case ($urandom_range(0, 5))
          0: addr[pos] = 8'($urandom_range(1, 255));
          1: addr[pos] = esc_pkg::CH_DOT;
          2: addr[pos] = esc_pkg::CH_AT;
          3: addr.insert(pos, esc_pkg::CH_AT);
          4: addr = addr[0:pos];
          default: addr[addr.size() - 1] = legal_char();
        endcase
      end
    end
    send_address(addr);
  endtask

  initial begin
    rst            <= 1'b1;
    cin.valid      <= 1'b0;
    cin.char_code  <= esc_pkg::CH_NONE;
    cin.last_char  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_text("a");
    send_text("@");
    send_text(".");
    send_text("b.com");
    send_text("a..com");
    send_text("a@@c.com");
    send_text("a\377.com");
    send_text("k.co.");

    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent > RANDOM_CHARS - 120) steady = 1'b1;
      send_random_address();
    end
    cin.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.failures == 0)
      $display("email_syntax_checker: match");
    else
      $display("email_syntax_checker: mismatch");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/esc_pkg.sv
src/esc_if.sv
src/esc_judge.sv
src/email_syntax_checker.sv
src/esc_checker.sv
sim/tb.sv
